// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files
// each macro expects i_clk and i_rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ECSTG_ASSERT_IMP(NAME, ANT, CON, MSG) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |-> (CON)) \
        else $error(MSG);

// next-cycle implication, checked out of reset
`define ECSTG_ASSERT_NXT(NAME, ANT, CON, MSG) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

// ===== hw/rtl/ecstg_pkg.sv =====
// types, codes and the note base table for the square tone generator
// no dependencies
`default_nettype none

package ecstg_pkg;

    localparam int NOTE_COUNT = 64;
    localparam int NOTE_SCALE = 11025;
    localparam int STEP_W     = 16;
    localparam int PHASE_W    = 20;
    localparam int GAIN_W     = 12;
    localparam int SAMPLE_W   = 19;
    localparam int ACC_W      = 7;   // tick sums stay within +-56
    localparam int PC_W       = 3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd1024;

    localparam logic [1:0] ACT_DATA = 2'd0;
    localparam logic [1:0] ACT_MASK = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [15:0] NOTE_BASE [NOTE_COUNT] = '{
        16'h0000, 16'h051B, 16'h0569, 16'h05BB, 16'h0613, 16'h066F, 16'h06D1, 16'h0739,
        16'h07A7, 16'h081B, 16'h0897, 16'h091A, 16'h09A4, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0A37, 16'h0AD3, 16'h0B77, 16'h0C26, 16'h0CDF, 16'h0DA3, 16'h0E72,
        16'h0F4E, 16'h1037, 16'h112E, 16'h1234, 16'h1349, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h146E, 16'h15A6, 16'h16EF, 16'h184C, 16'h19BE, 16'h1B46, 16'h1CE5,
        16'h1E9D, 16'h206F, 16'h225D, 16'h2468, 16'h2692, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h28DD, 16'h2B4C, 16'h2DDF, 16'h3099, 16'h337D, 16'h368D, 16'h39CB,
        16'h3D3B, 16'h40DF, 16'h44BA, 16'h48D1, 16'h4D25, 16'h51BB, 16'h0000, 16'h0000
    };

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
        logic [7:0] byte_mask;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_out_item;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_CLR,
        UOP_ADV,
        UOP_MUL,
        UOP_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        JC_START,
        JC_NEXT,
        JC_LOOP,
        JC_FREE
    } t_jcond;

    typedef struct packed {
        t_uop   op;
        t_jcond cond;
        t_pc    target;
    } t_uctl;

    typedef struct packed {
        logic start;
        logic loop_last;
        logic out_free;
    } t_useq_stat;

    localparam t_pc PC_WAIT = 3'd0;
    localparam t_pc PC_CLR  = 3'd1;
    localparam t_pc PC_ADV  = 3'd2;
    localparam t_pc PC_MUL  = 3'd3;
    localparam t_pc PC_EMIT = 3'd4;

    // tick program
    function automatic t_uctl uc_rom(input t_pc pc);
        t_uctl w;
        case (pc)
            PC_WAIT: w = '{op: UOP_WAIT, cond: JC_START, target: PC_WAIT};
            PC_CLR:  w = '{op: UOP_CLR,  cond: JC_NEXT,  target: PC_WAIT};
            PC_ADV:  w = '{op: UOP_ADV,  cond: JC_LOOP,  target: PC_WAIT};
            PC_MUL:  w = '{op: UOP_MUL,  cond: JC_NEXT,  target: PC_WAIT};
            PC_EMIT: w = '{op: UOP_EMIT, cond: JC_FREE,  target: PC_WAIT};
            default: w = '{op: UOP_WAIT, cond: JC_FREE,  target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ecstg_useq.sv =====
// step counter and control store of the tone generator sequencer
// depends on ecstg_pkg
`default_nettype none

module ecstg_useq (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  ecstg_pkg::t_useq_stat   i_stat,
    output ecstg_pkg::t_uctl        o_ctl
);
    import ecstg_pkg::*;

    t_pc   r_pc;
    t_pc   n_pc;
    t_uctl w_ctl;

    assign w_ctl = uc_rom(r_pc);
    assign o_ctl = w_ctl;

    always_comb begin
        case (w_ctl.cond)
            JC_START: n_pc = i_stat.start     ? r_pc + t_pc'(1) : r_pc;
            JC_NEXT:  n_pc = r_pc + t_pc'(1);
            JC_LOOP:  n_pc = i_stat.loop_last ? r_pc + t_pc'(1) : r_pc;
            JC_FREE:  n_pc = i_stat.out_free  ? w_ctl.target : r_pc;
            default:  n_pc = PC_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/eight_channel_square_tone_generator.sv =====
// eight-channel square tone generator, top level and datapath
// depends on ecstg_pkg, ecstg_useq and assert_macros.svh
//
// usage:
//   input channel (i_in_valid / o_in_ready / i_in) carries one item: a data
//   register write, an enable mask write or a sample tick. writes give no
//   result. a tick gives one stereo result item on the output channel
//   (o_out_valid / i_out_ready / o_out).
//   step_gain sits on an apb port at byte address 0; pready is tied high.
// tick sequence:
//   an accepted tick runs clear, 32 phase steps (8 channels x 4), multiply
//   and load into the output register. the input is ready again the cycle
//   after the load, so no new tick is taken until the last one is loaded.
//   the single shared 20-bit phase adder is stepped once per cycle under the
//   control store. writes are accepted one per cycle while the input is ready.
// reset:
//   synchronous active-low reset clears the latch, mask, key entry state,
//   all channel steps and phases, and sets step_gain to 1024.
// stall:
//   the result waits in the output register; writes are still accepted,
//   and a following tick runs its steps and then holds until the register frees
`default_nettype none

`include "assert_macros.svh"

module eight_channel_square_tone_generator #(
    parameter int SAMPLE_RATE = 44100
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // item input
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  ecstg_pkg::t_in_item     i_in,
    // result output
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output ecstg_pkg::t_out_item    o_out,
    // configuration
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [2:0]              paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import ecstg_pkg::*;

    // note table, folded at elaboration for this sample rate
    logic [STEP_W-1:0] w_note_step [NOTE_COUNT];

    for (genvar gi = 0; gi < NOTE_COUNT; gi++) begin : g_note
        localparam int unsigned PROD = int'(NOTE_BASE[gi]) * NOTE_SCALE;
        localparam int unsigned STEP = (PROD + SAMPLE_RATE) / (2 * SAMPLE_RATE);
        assign w_note_step[gi] = STEP_W'(STEP);
    end

    // configuration register
    logic [GAIN_W-1:0] r_gain;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {{(32-GAIN_W){1'b0}}, r_gain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (w_cfg_wr) begin
            r_gain <= pwdata[GAIN_W-1:0];
        end
    end

    // sequencer
    t_uctl      w_ctl;
    t_useq_stat w_stat;
    logic       w_in_acc;

    logic [2:0] r_ch;       // channel under step
    logic [1:0] r_k;        // phase step within the channel

    assign o_in_ready       = (w_ctl.op == UOP_WAIT);
    assign w_in_acc         = i_in_valid && o_in_ready;
    assign w_stat.start     = w_in_acc && (i_in.action == ACT_TICK);
    assign w_stat.loop_last = (r_k == 2'd3) && (r_ch == 3'd7);
    assign w_stat.out_free  = !o_out_valid || i_out_ready;

    ecstg_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    // register writes and key entry
    logic [7:0]        r_latch;
    logic [7:0]        r_en;
    logic              r_pending;
    logic [2:0]        r_cur;
    logic [STEP_W-1:0] r_step [8];
    logic [7:0]        w_merged;
    logic              w_data_wr;
    logic              w_key_load;

    assign w_data_wr  = w_in_acc && (i_in.action == ACT_DATA);
    assign w_merged   = (r_latch & ~i_in.byte_mask) | (i_in.data & i_in.byte_mask);
    // key load: second write with bit 7 held high while entry is armed
    assign w_key_load = w_data_wr && w_merged[7] && r_latch[7] && r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch   <= 8'd0;
            r_en      <= 8'd0;
            r_pending <= 1'b0;
            r_cur     <= 3'd0;
        end else if (w_in_acc) begin
            if (i_in.action == ACT_DATA) begin
                if (w_merged[7]) begin
                    if (!r_latch[7]) begin
                        // rising bit 7 opens key entry at channel 0
                        r_pending <= 1'b1;
                        r_cur     <= 3'd0;
                    end else if (r_pending) begin
                        r_pending <= 1'b0;
                    end else if (!w_merged[6] && r_latch[6]) begin
                        // falling bit 6 moves to the next channel, wraps past 7
                        r_pending <= 1'b1;
                        r_cur     <= r_cur + 3'd1;
                    end
                end
                r_latch <= w_merged;
            end else if (i_in.action == ACT_MASK) begin
                r_en <= (r_en & ~i_in.byte_mask) | (i_in.data & i_in.byte_mask);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_step[i] <= '0;
            end
        end else if (w_key_load) begin
            r_step[r_cur] <= w_note_step[w_merged[5:0]];
        end
    end

    // phase stepping, one channel step per cycle
    logic [PHASE_W-1:0]     r_phase [8];
    logic [PHASE_W-1:0]     w_sum;
    logic                   w_live;
    logic [2:0]             w_pop;
    logic signed [4:0]      w_level;    // 2*popcount-4
    logic signed [ACC_W-1:0] w_sq;      // square channel, +1 or -1
    logic signed [ACC_W-1:0] r_acc_l;
    logic signed [ACC_W-1:0] r_acc_r;

    assign w_live  = r_en[r_ch] && (r_step[r_ch] != '0);
    assign w_sum   = r_phase[r_ch] + {{(PHASE_W-STEP_W){1'b0}}, r_step[r_ch]};
    assign w_pop   = 3'(w_sum[16]) + 3'(w_sum[17]) + 3'(w_sum[18]) + 3'(w_sum[19]);
    assign w_level = $signed({1'b0, w_pop, 1'b0}) - 5'sd4;
    assign w_sq    = w_sum[16] ? ACC_W'(1) : -ACC_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_phase[i] <= '0;
            end
        end else if ((w_ctl.op == UOP_ADV) && w_live) begin
            r_phase[r_ch] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= 3'd0;
            r_k     <= 2'd0;
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else begin
            case (w_ctl.op)
                UOP_CLR: begin
                    r_ch    <= 3'd0;
                    r_k     <= 2'd0;
                    r_acc_l <= '0;
                    r_acc_r <= '0;
                end
                UOP_ADV: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_ch <= r_ch + 3'd1;
                    end
                    if (w_live) begin
                        if (r_ch < 3'd2) begin
                            // square channels feed both sides
                            r_acc_l <= r_acc_l + w_sq;
                            r_acc_r <= r_acc_r + w_sq;
                        end else if (r_ch < 3'd5) begin
                            r_acc_l <= r_acc_l + ACC_W'(w_level);
                        end else begin
                            r_acc_r <= r_acc_r + ACC_W'(w_level);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // gain scaling, one multiply per side
    logic signed [ACC_W+GAIN_W:0]  w_prod_l;
    logic signed [ACC_W+GAIN_W:0]  w_prod_r;
    logic signed [SAMPLE_W-1:0]    r_res_l;
    logic signed [SAMPLE_W-1:0]    r_res_r;

    assign w_prod_l = r_acc_l * $signed({1'b0, r_gain});
    assign w_prod_r = r_acc_r * $signed({1'b0, r_gain});

    always_ff @(posedge i_clk) begin
        if (w_ctl.op == UOP_MUL) begin
            r_res_l <= w_prod_l[SAMPLE_W-1:0];
            r_res_r <= w_prod_r[SAMPLE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if ((w_ctl.op == UOP_EMIT) && w_stat.out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_ctl.op == UOP_EMIT) && w_stat.out_free) begin
            o_out.left_sample  <= r_res_l;
            o_out.right_sample <= r_res_r;
        end
    end

    // checks
    `ECSTG_ASSERT_NXT(a_tick_busy, w_stat.start, !o_in_ready, "tick accepted but input still ready")
    `ECSTG_ASSERT_IMP(a_loop_wrap, w_ctl.op == UOP_MUL, (r_ch == 3'd0) && (r_k == 2'd0), "step counters not wrapped")
    `ECSTG_ASSERT_IMP(a_acc_range, 1'b1, (r_acc_l <= 7'sd56) && (r_acc_l >= -7'sd56) && (r_acc_r <= 7'sd56) && (r_acc_r >= -7'sd56), "accumulator out of range")

endmodule

`default_nettype wire
